/* hw/rtl/spline_arc_length_search_top_defines.svh */
// assertion macros used by the top-level rtl
`ifndef SPLINE_ARC_LENGTH_SEARCH_TOP_DEFINES_SVH
`define SPLINE_ARC_LENGTH_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define SALS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SALS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sals_pkg.sv */
`default_nettype none
package sals_pkg;

    localparam int MAX_SLICES = 4096;
    localparam int N_W = $clog2(MAX_SLICES + 1);

    localparam logic [63:0] DCAP = 64'h0080_0000_0000_0000;
    localparam logic [63:0] HCAP = 64'h0000_0080_0000_0000;
    localparam logic [63:0] LCAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LHCAP = 64'h0000_4000_0000_0000;
    localparam logic [30:0] SCAP = 31'h7fff_ffff;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_COEF_D = 3'd3;
    localparam logic [2:0] REG_COEF_E = 3'd4;
    localparam logic [2:0] REG_KNOT = 3'd5;
    localparam logic [2:0] REG_SLICES = 3'd6;

    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_START = 5'd1;
    localparam logic [4:0] OP_INC0 = 5'd2;
    localparam logic [4:0] OP_XMUL = 5'd3;
    localparam logic [4:0] OP_XSET = 5'd4;
    localparam logic [4:0] OP_HHI = 5'd5;
    localparam logic [4:0] OP_HLO = 5'd6;
    localparam logic [4:0] OP_HADD = 5'd7;
    localparam logic [4:0] OP_SQ = 5'd8;
    localparam logic [4:0] OP_SQRT = 5'd9;
    localparam logic [4:0] OP_ACC = 5'd10;
    localparam logic [4:0] OP_LHI = 5'd11;
    localparam logic [4:0] OP_LLO = 5'd12;
    localparam logic [4:0] OP_LDIV = 5'd13;
    localparam logic [4:0] OP_LEN = 5'd14;
    localparam logic [4:0] OP_ADV = 5'd15;
    localparam logic [4:0] OP_UV = 5'd16;
    localparam logic [4:0] OP_VSH = 5'd17;
    localparam logic [4:0] OP_FDIV = 5'd18;
    localparam logic [4:0] OP_PDIV = 5'd19;
    localparam logic [4:0] OP_PSET = 5'd20;
    localparam logic [4:0] OP_NOHIT = 5'd21;
    localparam logic [4:0] OP_OUT = 5'd22;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic horner_last;
        logic first_sample;
        logic last_sample;
        logic found;
        logic v_big;
    } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/sals_div.sv */
`default_nettype none
module sals_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quot,
    output logic [63:0]      rem
);
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[63]};
    assign fits = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? 64'(shifted - {1'b0, den_reg}) : shifted[63:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

/* hw/rtl/sals_sqrt.sv */
`default_nettype none
module sals_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] rad_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        fits;

    assign shifted = {rem_reg[33:0], rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= fits ? (shifted - trial) : shifted;
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

/* hw/rtl/sals_datapath.sv */
`default_nettype none
module sals_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sals_pkg::cmd_t cmd,
    output sals_pkg::sts_t      sts,
    input  wire logic           cfg_valid,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic [31:0]    target_distance,
    output logic [31:0]         total_length,
    output logic [30:0]         param_at_target,
    output logic                past_end
);
    import sals_pkg::*;

    logic [31:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg, coef_e_reg;
    logic [31:0] knot_reg;
    logic [12:0] slices_reg;

    logic [31:0] target_reg;
    logic [N_W-1:0] n_reg;
    logic [30:0] q0_reg;
    logic [N_W-1:0] r0_reg;
    logic [30:0] t_reg;
    logic [N_W-1:0] racc_reg;
    logic [N_W-1:0] i_reg;
    logic [63:0] prod_reg;
    logic [63:0] hi_reg;
    logic [31:0] x_reg;
    logic signed [56:0] acc_reg;
    logic [1:0]  k_reg;
    logic [31:0] fprev_reg;
    logic [45:0] sum_reg;
    logic [62:0] len_reg;
    logic [62:0] lo_reg;
    logic [62:0] hilen_reg;
    logic [N_W-1:0] hit_reg;
    logic        found_reg;
    logic [31:0] u_reg;
    logic [62:0] v_reg;
    logic [30:0] param_reg;
    logic [31:0] total_reg;
    logic [30:0] param_out_reg;
    logic        past_reg;

    logic [N_W-1:0] n_clamp;
    logic [31:0] mul_a, mul_b;
    logic        div_start, div_done, sqrt_start, sqrt_done;
    logic [63:0] div_n, div_d, div_q, div_r;
    logic [31:0] root;
    logic [56:0] mag;
    logic        acc_neg;
    logic [47:0] s_wide;
    logic [30:0] s_val;
    logic [63:0] hm_sum, hm_r;
    logic signed [58:0] hm_mag, hm_sm, term, hsum;
    logic signed [58:0] sx_b, sx_c, sx_d, sx_e;
    logic signed [56:0] five_a;
    logic [63:0] l_sum, l_cap;
    logic [N_W:0] rsum;
    logic [62:0] len_new;
    logic [42:0] pnum;

    always_comb
    begin
        if (slices_reg == 13'd0)
            n_clamp = N_W'(1);
        else if (32'(slices_reg) > 32'(MAX_SLICES))
            n_clamp = N_W'(MAX_SLICES);
        else
            n_clamp = N_W'(slices_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            coef_e_reg <= '0;
            knot_reg   <= 32'h0001_0000;
            slices_reg <= 13'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_A: coef_a_reg <= cfg_data;
                REG_COEF_B: coef_b_reg <= cfg_data;
                REG_COEF_C: coef_c_reg <= cfg_data;
                REG_COEF_D: coef_d_reg <= cfg_data;
                REG_COEF_E: coef_e_reg <= cfg_data;
                REG_KNOT:   knot_reg   <= cfg_data;
                REG_SLICES: slices_reg <= cfg_data[12:0];
                default:    ;
            endcase
        end
    end

    // slope magnitude and horner step
    assign acc_neg = acc_reg[56];
    assign mag = acc_neg ? 57'(-acc_reg) : 57'(acc_reg);
    assign s_wide = mag[55:8];
    assign s_val = (|s_wide[47:31]) ? SCAP : s_wide[30:0];

    assign sx_b = 59'(signed'(coef_b_reg));
    assign sx_c = 59'(signed'(coef_c_reg));
    assign sx_d = 59'(signed'(coef_d_reg));
    assign sx_e = 59'(signed'(coef_e_reg));
    assign five_a = (57'(signed'(coef_a_reg)) <<< 2) + 57'(signed'(coef_a_reg));

    assign hm_sum = (hi_reg << 16) + {16'b0, prod_reg[63:16]};
    assign hm_r = (hi_reg > HCAP) ? DCAP : ((hm_sum > DCAP) ? DCAP : hm_sum);
    assign hm_mag = signed'({1'b0, hm_r[57:0]});
    assign hm_sm = acc_neg ? -hm_mag : hm_mag;

    always_comb
    begin
        case (k_reg)
            2'd0:    term = sx_b <<< 2;
            2'd1:    term = (sx_c <<< 1) + sx_c;
            2'd2:    term = sx_d <<< 1;
            default: term = sx_e;
        endcase
    end

    assign hsum = hm_sm + term;

    // running length before the divide
    assign l_sum = (hi_reg << 16) + {16'b0, prod_reg[63:16]};
    assign l_cap = (hi_reg > LHCAP) ? LCAP : ((l_sum > LCAP) ? LCAP : l_sum);

    assign rsum = {1'b0, racc_reg} + {1'b0, r0_reg};
    assign len_new = div_q[62:0];
    assign pnum = {12'(hit_reg - N_W'(1)), 30'b0} + 43'(div_q[31:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_XMUL: begin mul_a = {1'b0, t_reg};          mul_b = knot_reg; end
            OP_HHI:  begin mul_a = {8'b0, mag[55:32]};     mul_b = x_reg;    end
            OP_HLO:  begin mul_a = mag[31:0];              mul_b = x_reg;    end
            OP_SQ:   begin mul_a = {1'b0, s_val};          mul_b = {1'b0, s_val}; end
            OP_LHI:  begin mul_a = {18'b0, sum_reg[45:32]}; mul_b = knot_reg; end
            OP_LLO:  begin mul_a = sum_reg[31:0];          mul_b = knot_reg; end
            default: ;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_n = '0;
        div_d = '0;
        case (cmd.op)
            OP_START:
            begin
                div_start = 1'b1;
                div_n = 64'h0000_0000_4000_0000;
                div_d = 64'(n_clamp);
            end
            OP_LDIV:
            begin
                div_start = 1'b1;
                div_n = l_cap;
                div_d = {50'b0, n_reg, 1'b0};
            end
            OP_FDIV:
            begin
                div_start = 1'b1;
                div_n = {2'b0, u_reg, 30'b0};
                div_d = {1'b0, v_reg};
            end
            OP_PDIV:
            begin
                div_start = 1'b1;
                div_n = 64'(pnum);
                div_d = 64'(n_reg);
            end
            default: ;
        endcase
    end

    assign sqrt_start = (cmd.op == OP_SQRT);

    sals_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    sals_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (64'h0000_0001_0000_0000 + prod_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_XMUL || cmd.op == OP_HHI || cmd.op == OP_HLO ||
            cmd.op == OP_SQ || cmd.op == OP_LHI || cmd.op == OP_LLO)
            prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_START:
            begin
                target_reg <= target_distance;
                n_reg      <= n_clamp;
                sum_reg    <= '0;
                len_reg    <= '0;
            end
            OP_INC0:
            begin
                q0_reg   <= div_q[30:0];
                r0_reg   <= div_r[N_W-1:0];
                t_reg    <= '0;
                racc_reg <= '0;
                i_reg    <= '0;
            end
            OP_XSET:
            begin
                x_reg   <= prod_reg[61:30];
                acc_reg <= five_a;
                k_reg   <= '0;
            end
            OP_HLO: hi_reg <= prod_reg;
            OP_HADD:
            begin
                if (hsum > 59'sh0_0080_0000_0000_0000)
                    acc_reg <= 57'sh0_0080_0000_0000_0000;
                else if (hsum < -59'sh0_0080_0000_0000_0000)
                    acc_reg <= -57'sh0_0080_0000_0000_0000;
                else
                    acc_reg <= hsum[56:0];
                k_reg <= k_reg + 2'd1;
            end
            OP_ACC:
            begin
                fprev_reg <= root;
                if (i_reg != '0)
                    sum_reg <= sum_reg + 46'(fprev_reg) + 46'(root);
            end
            OP_LLO: hi_reg <= prod_reg;
            OP_LEN:
            begin
                len_reg <= len_new;
                if (!found_reg && len_new > 63'(target_reg))
                begin
                    hit_reg   <= i_reg;
                    lo_reg    <= len_reg;
                    hilen_reg <= len_new;
                end
            end
            OP_ADV:
            begin
                i_reg <= i_reg + N_W'(1);
                if (rsum >= {1'b0, n_reg})
                begin
                    racc_reg <= N_W'(rsum - {1'b0, n_reg});
                    t_reg    <= t_reg + q0_reg + 31'd1;
                end
                else
                begin
                    racc_reg <= rsum[N_W-1:0];
                    t_reg    <= t_reg + q0_reg;
                end
            end
            OP_UV:
            begin
                u_reg <= 32'(63'(target_reg) - lo_reg);
                v_reg <= hilen_reg - lo_reg;
            end
            OP_VSH:
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
            end
            OP_PSET: param_reg <= (div_q > 64'(ONE_Q30)) ? ONE_Q30 : div_q[30:0];
            OP_NOHIT: param_reg <= ONE_Q30;
            OP_OUT:
            begin
                total_reg     <= (|len_reg[62:32]) ? 32'hffff_ffff : len_reg[31:0];
                param_out_reg <= param_reg;
                past_reg      <= !found_reg && (63'(target_reg) > len_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.op == OP_START)
            found_reg <= 1'b0;
        else if (cmd.op == OP_LEN && len_new > 63'(target_reg))
            found_reg <= 1'b1;
    end

    assign sts.div_done     = div_done;
    assign sts.sqrt_done    = sqrt_done;
    assign sts.horner_last  = (k_reg == 2'd3);
    assign sts.first_sample = (i_reg == '0);
    assign sts.last_sample  = (i_reg == n_reg);
    assign sts.found        = found_reg;
    assign sts.v_big        = |v_reg[62:33];

    assign total_length    = total_reg;
    assign param_at_target = param_out_reg;
    assign past_end        = past_reg;
endmodule
`default_nettype wire

/* hw/rtl/sals_ctrl.sv */
`default_nettype none
module sals_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           target_valid,
    output logic                target_stall,
    output logic                result_valid,
    input  wire logic           result_stall,
    input  wire sals_pkg::sts_t sts,
    output sals_pkg::cmd_t      cmd
);
    import sals_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_W0   = 5'd1;
    localparam logic [4:0] ST_INC0 = 5'd2;
    localparam logic [4:0] ST_XMUL = 5'd3;
    localparam logic [4:0] ST_XSET = 5'd4;
    localparam logic [4:0] ST_HHI  = 5'd5;
    localparam logic [4:0] ST_HLO  = 5'd6;
    localparam logic [4:0] ST_HADD = 5'd7;
    localparam logic [4:0] ST_SQ   = 5'd8;
    localparam logic [4:0] ST_SQRT = 5'd9;
    localparam logic [4:0] ST_WSQ  = 5'd10;
    localparam logic [4:0] ST_ACC  = 5'd11;
    localparam logic [4:0] ST_LHI  = 5'd12;
    localparam logic [4:0] ST_LLO  = 5'd13;
    localparam logic [4:0] ST_LDIV = 5'd14;
    localparam logic [4:0] ST_WLD  = 5'd15;
    localparam logic [4:0] ST_LEN  = 5'd16;
    localparam logic [4:0] ST_ADV  = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;
    localparam logic [4:0] ST_UV   = 5'd19;
    localparam logic [4:0] ST_VSH  = 5'd20;
    localparam logic [4:0] ST_WFD  = 5'd21;
    localparam logic [4:0] ST_PDIV = 5'd22;
    localparam logic [4:0] ST_WPD  = 5'd23;
    localparam logic [4:0] ST_PSET = 5'd24;
    localparam logic [4:0] ST_NOHIT = 5'd25;
    localparam logic [4:0] ST_OUT  = 5'd26;

    logic [4:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        valid_next = valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (target_valid)
                begin
                    cmd.op = OP_START;
                    state_next = ST_W0;
                end
            end
            ST_W0:   if (sts.div_done) state_next = ST_INC0;
            ST_INC0: begin cmd.op = OP_INC0; state_next = ST_XMUL; end
            ST_XMUL: begin cmd.op = OP_XMUL; state_next = ST_XSET; end
            ST_XSET: begin cmd.op = OP_XSET; state_next = ST_HHI; end
            ST_HHI:  begin cmd.op = OP_HHI;  state_next = ST_HLO; end
            ST_HLO:  begin cmd.op = OP_HLO;  state_next = ST_HADD; end
            ST_HADD:
            begin
                cmd.op = OP_HADD;
                state_next = sts.horner_last ? ST_SQ : ST_HHI;
            end
            ST_SQ:   begin cmd.op = OP_SQ;   state_next = ST_SQRT; end
            ST_SQRT: begin cmd.op = OP_SQRT; state_next = ST_WSQ; end
            ST_WSQ:  if (sts.sqrt_done) state_next = ST_ACC;
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                state_next = sts.first_sample ? ST_ADV : ST_LHI;
            end
            ST_LHI:  begin cmd.op = OP_LHI;  state_next = ST_LLO; end
            ST_LLO:  begin cmd.op = OP_LLO;  state_next = ST_LDIV; end
            ST_LDIV: begin cmd.op = OP_LDIV; state_next = ST_WLD; end
            ST_WLD:  if (sts.div_done) state_next = ST_LEN;
            ST_LEN:
            begin
                cmd.op = OP_LEN;
                state_next = sts.last_sample ? ST_FIN : ST_ADV;
            end
            ST_ADV:  begin cmd.op = OP_ADV;  state_next = ST_XMUL; end
            ST_FIN:  state_next = sts.found ? ST_UV : ST_NOHIT;
            ST_UV:   begin cmd.op = OP_UV;   state_next = ST_VSH; end
            ST_VSH:
            begin
                if (sts.v_big)
                    cmd.op = OP_VSH;
                else
                begin
                    cmd.op = OP_FDIV;
                    state_next = ST_WFD;
                end
            end
            ST_WFD:  if (sts.div_done) state_next = ST_PDIV;
            ST_PDIV: begin cmd.op = OP_PDIV; state_next = ST_WPD; end
            ST_WPD:  if (sts.div_done) state_next = ST_PSET;
            ST_PSET: begin cmd.op = OP_PSET; state_next = ST_OUT; end
            ST_NOHIT: begin cmd.op = OP_NOHIT; state_next = ST_OUT; end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = OP_OUT;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign target_stall = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
endmodule
`default_nettype wire

/* hw/rtl/spline_arc_length_search_top.sv */
// a reached target adds the fraction and parameter divides plus operand shifts, at most 30
// each slice: a sample (horner loop, square root), then the length divide for all but the first
// the next item is taken in idle, once the result is in the output register
// rst_n clears the controller and loads the register reset values
`default_nettype none
`include "spline_arc_length_search_top_defines.svh"
module spline_arc_length_search_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        target_valid,
    output logic             target_stall,
    input  wire logic [31:0] target_distance,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      total_length,
    output logic [30:0]      param_at_target,
    output logic             past_end
);
    import sals_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sals_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    sals_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_distance (target_distance),
        .total_length    (total_length),
        .param_at_target (param_at_target),
        .past_end        (past_end)
    );

    `SALS_ASSERT_NEXT(a_busy_after_accept, target_valid && !target_stall, target_stall, "not busy after accept")
    `SALS_ASSERT_NOW(a_param_range, result_valid, param_at_target <= ONE_Q30, "parameter above one")
    `SALS_ASSERT_NOW(a_past_end_sat, result_valid && past_end, param_at_target == ONE_Q30, "past end without saturation")
endmodule
`default_nettype wire
